/* hdl/cpd_pkg.sv */
package cpd_pkg;

  // Sliding window geometry
  localparam int unsigned FRAME_LEN = 22;
  localparam int unsigned CRC_SPAN  = 18;
  localparam int unsigned CRC_BITS  = CRC_SPAN * 8;
  localparam int unsigned CRC_CNT_W = $clog2(CRC_BITS);

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOR  = 32'hFFFF_FFFF;

  // Window bytes, index 0 is the oldest byte
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // Control of the bit-serial CRC engine
  typedef struct packed {
    logic start;
    logic step;
  } crc_ctl_t;

endpackage

/* hdl/cpd_window.sv */
module cpd_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            clear_i,
  input  logic [7:0]      byte_i,
  output cpd_pkg::frame_t window_o,
  output logic            full_o
);
  import cpd_pkg::*;

  localparam logic [4:0] FILL_MAX = 5'(FRAME_LEN);

  frame_t     win_q, win_d;
  logic [4:0] fill_q, fill_d;

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (clear_i) begin
      fill_d = '0;
    end else if (shift_i) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[FRAME_LEN-1] = byte_i;
      if (fill_q != FILL_MAX) begin
        fill_d = fill_q + 5'd1;
      end
    end
  end

  // Window contents are only read once a full run has been written since the last clear
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign window_o = win_q;
  assign full_o   = (fill_q == FILL_MAX);

endmodule

/* hdl/cpd_crc_serial.sv */
module cpd_crc_serial (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cpd_pkg::crc_ctl_t              ctl_i,
  input  logic                           bit_i,
  output logic [31:0]                    crc_o,
  output logic [cpd_pkg::CRC_CNT_W-1:0]  bit_idx_o,
  output logic                           done_o
);
  import cpd_pkg::*;

  localparam logic [CRC_CNT_W-1:0] LAST_BIT = CRC_CNT_W'(CRC_BITS - 1);

  logic [31:0]          crc_q, crc_d;
  logic [CRC_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (ctl_i.start) begin
      crc_d = CRC_INIT;
      cnt_d = '0;
    end else if (ctl_i.step) begin
      // LSB-first feedback of the reflected polynomial
      crc_d = (crc_q >> 1) ^ ((crc_q[0] ^ bit_i) ? CRC_POLY : 32'h0);
      cnt_d = cnt_q + CRC_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign crc_o     = crc_q;
  assign bit_idx_o = cnt_q;
  assign done_o    = ctl_i.step && (cnt_q == LAST_BIT);

endmodule

/* hdl/crc32_probability_packet_deframer_core.sv */
// Receiver for CRC-32 framed probability packets. Each input transaction carries either a
// UART byte (tuser 0) or a receive timeout (tuser 1) and yields exactly one output
// transaction. The last 22 bytes form a sliding window; a timeout empties it. Once the
// window is full and starts with the header 90 19 08 43, a bit-serial CRC-32 runs over
// its first 18 bytes, one bit per cycle, and the frame fields are then checked. Such a
// byte goes through acceptance, an evaluation step, one CRC step for each of the 144
// covered bits and a finishing step; any other byte or a timeout goes from evaluation
// straight to finishing. The next transaction is taken in the cycle after the result is
// registered, even while that result still waits for tready; a result stalls only if the
// previous one has not yet been taken. Output tuser is the status: 0 no frame, 1 accepted,
// 2 CRC error, 3 invalid fields, 4 repeated sequence. Payload fields are zero unless
// accepted; the three totals are the counters after this transaction.
module crc32_probability_packet_deframer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]   s_axis_tuser_i,   // [0] action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] payload_valid, [16:1] prob_left, [32:17] prob_center, [48:33] prob_right,
  // [80:49] sender_ms, [96:81] seq_number, [128:97] accepted_total,
  // [160:129] crc_error_total, [192:161] invalid_total, [199:193] zero
  output logic [199:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // [2:0] status
);
  import cpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_CRC    = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_CRC_ERR = 3'd2,
    ST_INVALID = 3'd3,
    ST_DUP     = 3'd4
  } status_e;

  localparam logic [7:0]  HDR0    = 8'h90;
  localparam logic [7:0]  HDR1    = 8'h19;
  localparam logic [7:0]  HDR2    = 8'h08;
  localparam logic [7:0]  HDR3    = 8'h43;
  localparam logic [15:0] Q15_ONE = 16'h8000;

  state_e state_q, state_d;
  logic   hdr_pass_q, hdr_pass_d;

  // Input transaction and window
  logic   in_fire;
  frame_t win;
  logic   win_full;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  cpd_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_fire && !s_axis_tuser_i[0]),
    .clear_i  (in_fire && s_axis_tuser_i[0]),
    .byte_i   (s_axis_tdata_i),
    .window_o (win),
    .full_o   (win_full)
  );

  // Timeout flag of the transaction under evaluation
  logic timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 1'b0;
    end else if (in_fire) begin
      timeout_q <= s_axis_tuser_i[0];
    end
  end

  // Bit-serial CRC over the first CRC_SPAN window bytes, LSB of each byte first
  crc_ctl_t             crc_ctl;
  logic [31:0]          crc_val;
  logic [CRC_CNT_W-1:0] crc_idx;
  logic                 crc_done;
  logic                 crc_bit;

  assign crc_ctl.start = (state_q == S_EVAL);
  assign crc_ctl.step  = (state_q == S_CRC);
  assign crc_bit       = win[crc_idx[CRC_CNT_W-1:3]][crc_idx[2:0]];

  cpd_crc_serial u_crc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (crc_ctl),
    .bit_i     (crc_bit),
    .crc_o     (crc_val),
    .bit_idx_o (crc_idx),
    .done_o    (crc_done)
  );

  // Frame fields, little endian
  logic [31:0] rx_crc;
  logic [31:0] src_ms;
  logic [15:0] seq;
  logic [15:0] prob_l, prob_c, prob_r;
  logic [7:0]  flag, rsvd;
  logic        hdr_match;

  assign rx_crc = {win[21], win[20], win[19], win[18]};
  assign src_ms = {win[7], win[6], win[5], win[4]};
  assign seq    = {win[9], win[8]};
  assign prob_l = {win[11], win[10]};
  assign prob_c = {win[13], win[12]};
  assign prob_r = {win[15], win[14]};
  assign flag   = win[16];
  assign rsvd   = win[17];

  assign hdr_match = (win[0] == HDR0) && (win[1] == HDR1) &&
                     (win[2] == HDR2) && (win[3] == HDR3);

  // Counters and last accepted sequence
  logic [15:0] last_seq_q;
  logic [31:0] acc_cnt_q, crc_cnt_q, inv_cnt_q;
  logic [31:0] acc_cnt_d, crc_cnt_d, inv_cnt_d;

  // Output register
  logic         out_valid_q;
  logic [199:0] out_data_q;
  status_e      out_status_q;
  logic         out_free;
  logic         finish_fire;

  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign finish_fire = (state_q == S_FINISH) && out_free;

  // Frame verdict
  status_e status;
  logic    fields_bad;
  logic    probs_bad;

  assign fields_bad = (seq == 16'd0) || (flag > 8'd1) || (rsvd != 8'd0);
  assign probs_bad  = (prob_l > Q15_ONE) || (prob_c > Q15_ONE) || (prob_r > Q15_ONE) ||
                      ((flag == 8'd0) &&
                       ((prob_l != 16'd0) || (prob_c != 16'd0) || (prob_r != 16'd0)));

  always_comb begin
    if (!hdr_pass_q) begin
      status = ST_NONE;
    end else if ((crc_val ^ CRC_XOR) != rx_crc) begin
      status = ST_CRC_ERR;
    end else if (fields_bad || probs_bad) begin
      status = ST_INVALID;
    end else if (seq == last_seq_q) begin
      status = ST_DUP;
    end else begin
      status = ST_ACCEPT;
    end
  end

  always_comb begin
    acc_cnt_d = acc_cnt_q;
    crc_cnt_d = crc_cnt_q;
    inv_cnt_d = inv_cnt_q;
    if (status == ST_ACCEPT)  acc_cnt_d = acc_cnt_q + 32'd1;
    if (status == ST_CRC_ERR) crc_cnt_d = crc_cnt_q + 32'd1;
    if (status == ST_INVALID) inv_cnt_d = inv_cnt_q + 32'd1;
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    hdr_pass_d = hdr_pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EVAL;
      end
      S_EVAL: begin
        // Window already advanced: decide whether a CRC pass is needed
        hdr_pass_d = !timeout_q && win_full && hdr_match;
        state_d    = hdr_pass_d ? S_CRC : S_FINISH;
      end
      S_CRC: begin
        if (crc_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      hdr_pass_q <= 1'b0;
      last_seq_q <= '0;
      acc_cnt_q  <= '0;
      crc_cnt_q  <= '0;
      inv_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      hdr_pass_q <= hdr_pass_d;
      if (finish_fire) begin
        acc_cnt_q <= acc_cnt_d;
        crc_cnt_q <= crc_cnt_d;
        inv_cnt_q <= inv_cnt_d;
        if (status == ST_ACCEPT) last_seq_q <= seq;
      end
    end
  end

  // Hold the result until the downstream transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      out_status_q <= status;
      if (status == ST_ACCEPT) begin
        out_data_q <= {7'd0, inv_cnt_d, crc_cnt_d, acc_cnt_d, seq, src_ms,
                       prob_r, prob_c, prob_l, flag[0]};
      end else begin
        out_data_q <= {7'd0, inv_cnt_d, crc_cnt_d, acc_cnt_d, 97'd0};
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  // Checks
  a_crc_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC) |-> hdr_pass_q)
    else $error("CRC pass running without a header match");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_FINISH))
    else $error("result raised outside the finishing step");

  a_counters_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(acc_cnt_q) || !$stable(crc_cnt_q) || !$stable(inv_cnt_q))
      |-> $past(finish_fire))
    else $error("counter changed outside a finished transaction");

  a_crc_done_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_done |=> (state_q == S_FINISH))
    else $error("CRC completion did not lead to the finishing step");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cpd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int TOTAL_EVENTS = 1350;
  localparam int PHASE1_ITEMS = 550;
  localparam int PHASE2_ITEMS = 1100;
  localparam int HOLD_AT = 800;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 200;

  localparam logic [31:0] FRAME_HEADER = 32'h4308_1990;  // bytes 90 19 08 43
  localparam int unsigned Q15_ONE = 32768;

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_TIMEOUT = 1'b1
  } rx_action_e;

  typedef enum logic [2:0] {
    ST_NO_FRAME  = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_CRC_ERROR = 3'd2,
    ST_INVALID   = 3'd3,
    ST_DUPLICATE = 3'd4
  } frame_status_e;

  typedef struct packed {
    rx_action_e  action;
    logic [7:0]  rx_byte;
  } rx_event_t;

  typedef struct packed {
    frame_status_e status;
    logic          payload_valid;
    logic [15:0]   prob_left;
    logic [15:0]   prob_center;
    logic [15:0]   prob_right;
    logic [31:0]   sender_ms;
    logic [15:0]   seq_number;
    logic [31:0]   accepted_total;
    logic [31:0]   crc_error_total;
    logic [31:0]   invalid_total;
  } deframe_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;   // [7:0] rx_byte
  logic [0:0]   s_axis_tuser_i = '0;   // [0] action
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // [0] payload_valid, [16:1] prob_left, [32:17] prob_center, [48:33] prob_right,
  // [80:49] sender_ms, [96:81] seq_number, [128:97] accepted_total,
  // [160:129] crc_error_total, [192:161] invalid_total, [199:193] zero
  logic [199:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;        // [2:0] status

  crc32_probability_packet_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Byte stream waiting to be sent and the results predicted for sent transactions
  rx_event_t       byte_stream[$];
  deframe_result_t predicted_results[$];
  rx_event_t       offered;
  int unsigned     queued_total = 0;
  int unsigned     sent_items = 0;
  int unsigned     results_seen = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     hold_left = 0;
  logic            hold_done = 1'b0;

  // Shadow state of the receiver
  frame_t      shadow_window = '0;
  int unsigned fill_level = 0;
  logic [15:0] last_seq = '0;
  logic [31:0] accepted_cnt = '0;
  logic [31:0] crc_err_cnt = '0;
  logic [31:0] invalid_cnt = '0;

  // Reflected CRC-32 over the leading bytes of a frame
  function automatic logic [31:0] frame_crc(input frame_t f);
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      c ^= {24'b0, f[i]};
      for (int b = 0; b < 8; b++)
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c ^ CRC_XOR;
  endfunction

  // Advance the shadow receiver by one transaction and produce its result
  task automatic deframe_step(input rx_event_t ev, output deframe_result_t res);
    logic [15:0]       seq;
    logic [7:0]        flag;
    logic [2:0][15:0]  prob;
    logic              bad;
    res = '0;
    if (ev.action == ACT_TIMEOUT) begin
      fill_level = 0;
    end else begin
      // index 0 holds the oldest byte
      shadow_window = {ev.rx_byte, shadow_window[FRAME_LEN-1:1]};
      if (fill_level < FRAME_LEN) fill_level++;
      if (fill_level == FRAME_LEN && shadow_window[3:0] == FRAME_HEADER) begin
        if (frame_crc(shadow_window) != shadow_window[21:18]) begin
          crc_err_cnt++;
          res.status = ST_CRC_ERROR;
        end else begin
          seq  = shadow_window[9:8];
          flag = shadow_window[16];
          prob = shadow_window[15:10];
          bad  = (seq == 16'd0) || (flag > 8'd1) || (shadow_window[17] != 8'd0);
          for (int i = 0; i < 3; i++)
            bad |= (prob[i] > Q15_ONE) || (flag == 8'd0 && prob[i] != 16'd0);
          if (bad) begin
            invalid_cnt++;
            res.status = ST_INVALID;
          end else if (seq == last_seq) begin
            res.status = ST_DUPLICATE;
          end else begin
            last_seq = seq;
            accepted_cnt++;
            res.status        = ST_ACCEPTED;
            res.payload_valid = flag[0];
            res.prob_left     = prob[0];
            res.prob_center   = prob[1];
            res.prob_right    = prob[2];
            res.sender_ms     = shadow_window[7:4];
            res.seq_number    = seq;
          end
        end
      end
    end
    res.accepted_total  = accepted_cnt;
    res.crc_error_total = crc_err_cnt;
    res.invalid_total   = invalid_cnt;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h (result %0d)",
                                name, got, want, results_seen));
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_stream.push_back('{ACT_BYTE, b});
    queued_total++;
  endtask

  // Data byte on a timeout is don't-care: randomize it
  task automatic push_timeout();
    byte_stream.push_back('{ACT_TIMEOUT, 8'($urandom)});
    queued_total++;
  endtask

  // Build a frame, optionally corrupt its CRC, and send its first cut bytes
  task automatic push_frame(input logic [31:0] ms, input logic [15:0] seq,
                            input logic [15:0] pl, input logic [15:0] pc,
                            input logic [15:0] pr, input logic [7:0] flag,
                            input logic [7:0] rsvd, input logic [31:0] crc_mask,
                            input logic [31:0] hdr, input int unsigned cut);
    frame_t f;
    f = '0;
    f[3:0]   = hdr;
    f[7:4]   = ms;
    f[9:8]   = seq;
    f[11:10] = pl;
    f[13:12] = pc;
    f[15:14] = pr;
    f[16]    = flag;
    f[17]    = rsvd;
    f[21:18] = frame_crc(f) ^ crc_mask;
    for (int i = 0; i < cut; i++) push_byte(f[i]);
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'(Q15_ONE);
      default: return 16'($urandom_range(Q15_ONE));
    endcase
  endfunction

  // Driver: offer the next byte or timeout, predict each accepted transaction
  always @(posedge clk_i) begin
    deframe_result_t want;
    int unsigned     pct;
    pct = (sent_items < PHASE1_ITEMS) ? 29 : (sent_items < PHASE2_ITEMS) ? 56 : 0;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        deframe_step(offered, want);
        predicted_results.push_back(want);
        sent_items++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= pct) begin
          offered = byte_stream.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= offered.rx_byte;
          s_axis_tuser_i  <= offered.action;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    deframe_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing predicted, status %0d",
                                  m_axis_tuser_o));
      end else begin
        want = predicted_results.pop_front();
        check_field("status",          m_axis_tuser_o,           want.status);
        check_field("payload_valid",   m_axis_tdata_o[0],        want.payload_valid);
        check_field("prob_left",       m_axis_tdata_o[16:1],     want.prob_left);
        check_field("prob_center",     m_axis_tdata_o[32:17],    want.prob_center);
        check_field("prob_right",      m_axis_tdata_o[48:33],    want.prob_right);
        check_field("sender_ms",       m_axis_tdata_o[80:49],    want.sender_ms);
        check_field("seq_number",      m_axis_tdata_o[96:81],    want.seq_number);
        check_field("accepted_total",  m_axis_tdata_o[128:97],   want.accepted_total);
        check_field("crc_error_total", m_axis_tdata_o[160:129],  want.crc_error_total);
        check_field("invalid_total",   m_axis_tdata_o[192:161],  want.invalid_total);
        check_field("tdata padding",   m_axis_tdata_o[199:193],  '0);
      end
      results_seen <= results_seen + 1;
    end
  end

  // Receiver: random back-pressure plus one long hold-off so the core fills up
  always @(posedge clk_i) begin
    int unsigned pct;
    pct = (results_seen < PHASE1_ITEMS) ? 56 : (results_seen < PHASE2_ITEMS) ? 29 : 0;
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left       <= HOLD_CYCLES;
        hold_done       <= 1'b1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= pct);
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] prev_seq;
    logic [15:0] seq, pl, pc, pr;
    logic [7:0]  flag, rsvd;
    logic [31:0] crc_mask;
    logic        valid;
    int unsigned kind;
    int unsigned cut;

    // Too few bytes to fill the window, then a timeout empties it
    repeat (7) push_byte(8'($urandom));
    push_timeout();
    // Extreme timestamp and sequence, probabilities at both limits: accepted
    push_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd32768, 16'd0, 16'd32767, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    // Same frame again: repeated sequence
    push_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd32768, 16'd0, 16'd32767, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    // Not valid, all probabilities zero, smallest timestamp and sequence: accepted
    push_frame(32'h0, 16'd1, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    // Corrupted CRC
    push_frame(32'h1234_5678, 16'h0102, 16'd100, 16'd200, 16'd300, 8'd1, 8'd0,
               32'h8000_0001, FRAME_HEADER, FRAME_LEN);
    // Bad fields: sequence zero, flag above one, reserved byte set
    push_frame(32'h0000_0055, 16'd0, 16'd1, 16'd2, 16'd3, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    push_frame(32'h0000_0066, 16'd9, 16'd1, 16'd2, 16'd3, 8'hFF, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    push_frame(32'h0000_0077, 16'd9, 16'd1, 16'd2, 16'd3, 8'd1, 8'hFF,
               32'h0, FRAME_HEADER, FRAME_LEN);
    // Probability just above one and at the top of its range
    push_frame(32'hA5A5_5A5A, 16'd10, 16'd32769, 16'd0, 16'd0, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    push_frame(32'h5A5A_A5A5, 16'd11, 16'd0, 16'd0, 16'hFFFF, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    // Nonzero probability while not valid
    push_frame(32'h0F0F_F0F0, 16'd12, 16'd0, 16'd1, 16'd0, 8'd0, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    // Wrong last header byte with a self-consistent CRC: no frame
    push_frame(32'h0000_0001, 16'd13, 16'd5, 16'd5, 16'd5, 8'd1, 8'd0,
               32'h0, FRAME_HEADER ^ 32'h0100_0000, FRAME_LEN);
    // Frame cut short by a timeout, then a complete one
    push_frame(32'h0000_0002, 16'd14, 16'd5, 16'd5, 16'd5, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, 10);
    push_timeout();
    push_frame(32'h0000_0003, 16'd15, 16'd7, 16'd8, 16'd9, 8'd1, 8'd0,
               32'h0, FRAME_HEADER, FRAME_LEN);
    prev_seq = 16'd15;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold the sender until every directed result has come back
    while (byte_stream.size() != 0 || s_axis_tvalid_i || predicted_results.size() != 0)
      @(negedge clk_i);
    @(negedge clk_i);

    while (queued_total < TOTAL_EVENTS) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        // Mostly well-formed frames with random content, some with one flaw
        repeat ($urandom_range(3)) push_byte(8'($urandom));
        if ($urandom_range(9) == 0) push_timeout();
        valid    = 1'($urandom_range(1));
        seq      = ($urandom_range(4) == 0) ? prev_seq : 16'($urandom_range(1, 16'hFFFF));
        pl       = valid ? rand_prob() : 16'd0;
        pc       = valid ? rand_prob() : 16'd0;
        pr       = valid ? rand_prob() : 16'd0;
        flag     = {7'd0, valid};
        rsvd     = 8'd0;
        crc_mask = 32'h0;
        case ($urandom_range(11))
          0: crc_mask = 32'h1 << $urandom_range(31);
          1: seq  = 16'd0;
          2: flag = 8'($urandom_range(2, 255));
          3: rsvd = 8'($urandom_range(1, 255));
          4: pc   = 16'($urandom_range(Q15_ONE + 1, 16'hFFFF));
          5: if (!valid) pr = 16'($urandom_range(1, 16'hFFFF));
          default: ;
        endcase
        prev_seq = seq;
        push_frame($urandom, seq, pl, pc, pr, flag, rsvd, crc_mask, FRAME_HEADER, FRAME_LEN);
      end else if (kind < 75) begin
        push_timeout();
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 30)) push_byte(8'($urandom));
      end else begin
        // Broken frame: header and part of the body, maybe a timeout after it
        cut = $urandom_range(4, FRAME_LEN - 1);
        push_frame($urandom, 16'($urandom), rand_prob(), rand_prob(), rand_prob(),
                   8'($urandom_range(1)), 8'd0, 32'h0, FRAME_HEADER, cut);
        if ($urandom_range(1) == 0) push_timeout();
      end
    end

    // Drain: wait for the last result, then let any late output show up
    while (byte_stream.size() != 0 || s_axis_tvalid_i || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
hdl/cpd_pkg.sv
hdl/cpd_window.sv
hdl/cpd_crc_serial.sv
hdl/crc32_probability_packet_deframer_core.sv
verif/testbench.sv
